// File: src/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types, character codes and register indexes of the ascii integer
// parser.
// ----------------------------------------------------------------------------
package aip_pkg;

    // parse phases of the back end
    typedef enum logic [2:0] {
        PH_BLANK  = 3'd0,
        PH_PREFIX = 3'd1,
        PH_ZERO   = 3'd2,
        PH_DIGITS = 3'd3
    } parse_phase_t;

    // one classified character as it travels from front to back
    typedef struct packed {
        logic       is_nul;
        logic       is_blank;
        logic       is_minus;
        logic       is_plus;
        logic       is_zero;
        logic       is_x;
        logic [3:0] digit;
    } char_class_t;

    // configuration register indexes
    localparam logic [7:0] CFG_IDX_NUMBER_BASE = 8'd0;
    localparam logic [7:0] CFG_IDX_SIGNED_MODE = 8'd1;

    // register reset values
    localparam logic [7:0] BASE_RESET        = 8'd10;
    localparam logic       SIGNED_MODE_RESET = 1'b1;

    // radix limits
    localparam logic [7:0] BASE_MIN = 8'd2;
    localparam logic [7:0] BASE_MAX = 8'd16;
    localparam logic [4:0] BASE_HEX = 5'd16;

    // character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_X     = 8'h78;

    // configured base as used by the parser, zero when out of range
    function automatic logic [4:0] latch_base(input logic [7:0] base);
        if (base >= BASE_MIN && base <= BASE_MAX) begin
            return base[4:0];
        end
        return 5'd0;
    endfunction

endpackage

// File: src/aip_front.sv
// ----------------------------------------------------------------------------
// aip_front
// Input stage: takes one character per transfer, classifies it and holds the
// classified item in a register until the queue takes it.
// ----------------------------------------------------------------------------
module aip_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_char_byte,
    output logic                 f_valid,
    input  logic                 f_ready,
    output aip_pkg::char_class_t f_item
);
    import aip_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    char_class_t item_reg;
    char_class_t item_next;
    logic [7:0]  digit_wide;

    // hex digit value, any other character counts as zero
    always_comb begin
        case (s_char_byte) inside
            [8'h41:8'h46]: digit_wide = s_char_byte - 8'h37;
            [8'h61:8'h66]: digit_wide = s_char_byte - 8'h57;
            [8'h30:8'h39]: digit_wide = s_char_byte - CHAR_ZERO;
            default:       digit_wide = 8'd0;
        endcase
    end

    // character classes
    always_comb begin
        item_next.is_nul   = (s_char_byte == CHAR_NUL);
        item_next.is_blank = (s_char_byte == CHAR_SPACE) || (s_char_byte == CHAR_TAB);
        item_next.is_minus = (s_char_byte == CHAR_MINUS);
        item_next.is_plus  = (s_char_byte == CHAR_PLUS);
        item_next.is_zero  = (s_char_byte == CHAR_ZERO);
        item_next.is_x     = (s_char_byte == CHAR_X);
        item_next.digit    = digit_wide[3:0];
    end

    // take a new character when the holding register is empty or draining
    assign s_ready = !valid_reg || f_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

    assign f_valid = valid_reg;
    assign f_item  = item_reg;

endmodule

// File: src/aip_queue.sv
// ----------------------------------------------------------------------------
// aip_queue
// Small first-in first-out queue of classified characters between the front
// and the back end.
// ----------------------------------------------------------------------------
module aip_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  aip_pkg::char_class_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output aip_pkg::char_class_t out_item
);
    import aip_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    char_class_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   push;
    logic                   pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    // fill count never passes the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count above depth");

    // pointers are equal exactly when the queue is empty or full
    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg == rd_ptr_reg) == (count_reg == '0 || count_reg == CNT_W'(DEPTH)))
        else $error("queue pointers disagree with fill count");

endmodule

// File: src/aip_back.sv
// ----------------------------------------------------------------------------
// aip_back
// Back end: runs the parse sequencer over classified characters, keeps the
// 64-bit accumulator and holds the finished value in an output register.
// ----------------------------------------------------------------------------
module aip_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           cfg_number_base,
    input  logic                 cfg_signed_mode,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  aip_pkg::char_class_t q_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [63:0]          m_parsed_value,
    output logic                 m_bad_base
);
    import aip_pkg::*;

    parse_phase_t phase_reg;
    parse_phase_t phase_next;
    logic         minus_reg;
    logic         minus_next;
    logic [63:0]  acc_reg;
    logic [63:0]  acc_next;
    logic [4:0]   base_reg;
    logic [4:0]   base_next;
    logic         m_valid_reg;
    logic         m_valid_next;
    logic [63:0]  m_value_reg;
    logic [63:0]  m_value_next;
    logic         m_bad_reg;
    logic         m_bad_next;

    logic         step;
    logic [4:0]   base_now;
    logic [63:0]  mac;
    logic         take_sign;

    // a character is processed when the output register can take a result
    assign q_ready = !m_valid_reg || m_ready;
    assign step    = q_valid && q_ready;

    // base follows the register while blanks are skipped, then stays frozen
    assign base_now  = (phase_reg == PH_BLANK) ? latch_base(cfg_number_base) : base_reg;

    // accumulator times a 5-bit base as a sum of shifted copies, plus the digit
    assign mac       = (base_now[0] ? acc_reg : 64'd0)
                     + (base_now[1] ? {acc_reg[62:0], 1'b0} : 64'd0)
                     + (base_now[2] ? {acc_reg[61:0], 2'b0} : 64'd0)
                     + (base_now[3] ? {acc_reg[60:0], 3'b0} : 64'd0)
                     + (base_now[4] ? {acc_reg[59:0], 4'b0} : 64'd0)
                     + 64'(q_item.digit);
    assign take_sign = cfg_signed_mode && (q_item.is_minus || q_item.is_plus);

    // next parse phase
    always_comb begin
        phase_next = phase_reg;
        if (step) begin
            if (q_item.is_nul) begin
                phase_next = PH_BLANK;
            end else begin
                case (phase_reg)
                    PH_BLANK: begin
                        if (q_item.is_blank) begin
                            phase_next = PH_BLANK;
                        end else if (take_sign) begin
                            phase_next = PH_PREFIX;
                        end else if (q_item.is_zero) begin
                            phase_next = PH_ZERO;
                        end else begin
                            phase_next = PH_DIGITS;
                        end
                    end
                    PH_PREFIX: begin
                        phase_next = q_item.is_zero ? PH_ZERO : PH_DIGITS;
                    end
                    default: phase_next = PH_DIGITS;
                endcase
            end
        end
    end

    // accumulator, sign, base and result
    always_comb begin
        minus_next   = minus_reg;
        acc_next     = acc_reg;
        base_next    = base_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        m_bad_next   = m_bad_reg;
        if (step) begin
            if (phase_reg == PH_BLANK) begin
                base_next = base_now;
            end
            if (q_item.is_nul) begin
                // terminator: publish the value and restart
                m_valid_next = 1'b1;
                m_bad_next   = (base_now == 5'd0);
                if (base_now == 5'd0) begin
                    m_value_next = '0;
                end else begin
                    m_value_next = minus_reg ? (64'd0 - acc_reg) : acc_reg;
                end
                minus_next = 1'b0;
                acc_next   = '0;
                base_next  = latch_base(cfg_number_base);
            end else begin
                case (phase_reg)
                    PH_BLANK: begin
                        if (q_item.is_blank) begin
                            acc_next = acc_reg;
                        end else if (take_sign) begin
                            minus_next = q_item.is_minus;
                        end else if (!q_item.is_zero) begin
                            acc_next = mac;
                        end
                    end
                    PH_PREFIX: begin
                        if (!q_item.is_zero) begin
                            acc_next = mac;
                        end
                    end
                    PH_ZERO: begin
                        if (q_item.is_x) begin
                            if (base_reg != 5'd0) begin
                                base_next = BASE_HEX;
                            end
                            acc_next = '0;
                        end else begin
                            acc_next = 64'(q_item.digit);
                        end
                    end
                    default: acc_next = mac;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_BLANK;
            minus_reg   <= 1'b0;
            acc_reg     <= '0;
            base_reg    <= latch_base(BASE_RESET);
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            minus_reg   <= minus_next;
            acc_reg     <= acc_next;
            base_reg    <= base_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg <= m_value_next;
        m_bad_reg   <= m_bad_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_parsed_value = m_value_reg;
    assign m_bad_base     = m_bad_reg;

    // an invalid base always reports a zero value
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_bad_reg |-> m_value_reg == 64'd0)
        else $error("bad base result with nonzero value");

    // a minus sign is only pending inside a string
    a_minus_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        minus_reg |-> phase_reg != PH_BLANK)
        else $error("minus flag set while skipping blanks");

    // a frozen base is either zero or a legal radix
    a_base_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_BLANK |->
            base_reg == 5'd0 || (base_reg >= 5'd2 && base_reg <= BASE_HEX))
        else $error("frozen base out of range");

endmodule

// File: src/ascii_integer_parser.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Streaming text-to-integer converter with a classifying front end, a short
// queue and a parse back end.
// ----------------------------------------------------------------------------
// Takes one character per transfer and produces one 64-bit result on each NUL
// byte. A character is accepted every cycle while no result waits and QUEUE_DEPTH
// is at least 2; the rate is set by the back end's multiply-accumulate on the
// 64-bit accumulator, and a character passes the front register and the queue
// before the back end acts on it. While a result waits on the result side the
// back end takes no characters; the queue of QUEUE_DEPTH entries and the front
// register then hold up to QUEUE_DEPTH + 1 characters before the input stalls.
// Register 0 holds the radix (2 to 16, otherwise the result is zero with
// bad_base set) and register 1 the signed mode; the radix is sampled while
// leading blanks are skipped and frozen at the first other character. Write
// configuration only while no string is open.
module ascii_integer_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_parsed_value,
    output logic        m_bad_base
);
    import aip_pkg::*;

    logic [7:0]  base_cfg_reg;
    logic        signed_mode_reg;
    logic        f_valid;
    logic        f_ready;
    char_class_t f_item;
    logic        q_valid;
    logic        q_ready;
    char_class_t q_item;

    // configuration registers, writes to unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_cfg_reg    <= BASE_RESET;
            signed_mode_reg <= SIGNED_MODE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IDX_NUMBER_BASE: base_cfg_reg    <= cfg_data;
                CFG_IDX_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    aip_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_byte (s_char_byte),
        .f_valid     (f_valid),
        .f_ready     (f_ready),
        .f_item      (f_item)
    );

    aip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    aip_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_number_base (base_cfg_reg),
        .cfg_signed_mode (signed_mode_reg),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_parsed_value  (m_parsed_value),
        .m_bad_base      (m_bad_base)
    );

endmodule
